@@ hw/rtl/sus_pkg.sv @@
// ----------------------------------------------------------------------------
// sus_pkg
// Shared types and codes for the sorted unique set engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sus_pkg;

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int IN_VAL_W = 32;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

    // Update command broadcast along the row of cells
    typedef struct packed {
        logic upd;   // update this cycle
        logic ins;   // open a slot and write the new value
        logic rem;   // close the slot holding the matching value
        logic clr;   // drop every entry
    } sus_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/sus_cell.sv @@
// ----------------------------------------------------------------------------
// sus_cell
// One slot of the sorted row: holds a value and its valid flag, compares it
// against the incoming value and shifts with its neighbours on update.
// ----------------------------------------------------------------------------
`default_nettype none

module sus_cell #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire logic [VALUE_BITS-1:0] cmp_value,
    input  wire sus_pkg::sus_ctrl_t    ctrl,
    input  wire logic [VALUE_BITS-1:0] new_value,
    input  wire logic [VALUE_BITS-1:0] left_value,
    input  wire logic                  left_valid,
    input  wire logic                  left_lt,
    input  wire logic [VALUE_BITS-1:0] right_value,
    input  wire logic                  right_valid,
    output logic [VALUE_BITS-1:0]      value_q,
    output logic                       valid_q,
    output logic                       lt_q,
    output logic                       eq_q
);
    import sus_pkg::*;

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic                  lt_reg;
    logic                  eq_reg;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.ins && !lt_reg)
        begin
            // first slot not below the value takes it, the rest shift right
            if (left_lt)
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
            else
            begin
                value_next = left_value;
                valid_next = left_valid;
            end
        end
        else if (ctrl.rem && !lt_reg)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                lt_reg <= valid_reg && ($signed(value_reg) < $signed(cmp_value));
                eq_reg <= valid_reg && (value_reg == cmp_value);
            end
            if (ctrl.upd)
            begin
                valid_reg <= valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.upd)
        begin
            value_reg <= value_next;
        end
    end

    assign value_q = value_reg;
    assign valid_q = valid_reg;
    assign lt_q    = lt_reg;
    assign eq_q    = eq_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sorted_unique_set_engine.sv @@
// ----------------------------------------------------------------------------
// sorted_unique_set_engine
// Bounded ascending set of signed integers with insert, remove and clear,
// kept in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Each cell registers its compare on the input transfer edge. The whole row
// then shifts and the result is registered once the output register is free
// or being taken; a result left waiting there stalls the shift, and no input
// is taken from the transfer until the shift.
// The next input is taken while a result waits on the output register.
// Reset: asynchronous, active low; empties the set and drops any result.
`default_nettype none

module sorted_unique_set_engine #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // func[1:0], value[33:2], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // status[2:0], entry_count[7:3]
);
    import sus_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                  busy_reg;
    logic [FUNC_W-1:0]     func_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic [COUNT_W-1:0]    out_count_reg;
    logic [COUNT_W-1:0]    out_count;

    logic [VALUE_BITS-1:0] in_value;
    logic                  accept;
    logic                  do_upd;
    logic                  found;
    logic                  full;
    sus_ctrl_t             ctrl;

    logic [VALUE_BITS-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]   cell_valid;
    logic [CAPACITY-1:0]   cell_lt;
    logic [CAPACITY-1:0]   cell_eq;

    generate
        if (VALUE_BITS <= IN_VAL_W)
        begin : g_val_trunc
            assign in_value = s_tdata[FUNC_W +: VALUE_BITS];
        end
        else
        begin : g_val_ext
            assign in_value = {{(VALUE_BITS-IN_VAL_W){s_tdata[FUNC_W+IN_VAL_W-1]}},
                               s_tdata[FUNC_W +: IN_VAL_W]};
        end

        if (CNT_W >= COUNT_W)
        begin : g_cnt_trunc
            assign out_count = count_next[COUNT_W-1:0];
        end
        else
        begin : g_cnt_ext
            assign out_count = {{(COUNT_W-CNT_W){1'b0}}, count_next};
        end
    endgenerate

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && !busy_reg;
    assign do_upd   = busy_reg && (!out_valid_reg || m_tready);

    assign found = |cell_eq;
    assign full  = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        ctrl        = '0;
        ctrl.upd    = do_upd;
        count_next  = count_reg;
        status_next = ST_NOT_FOUND;
        case (func_reg)
            FUNC_INSERT:
            begin
                if (found)
                begin
                    status_next = ST_DUPLICATE;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_INSERTED;
                    ctrl.ins    = 1'b1;
                    count_next  = count_reg + 1'b1;
                end
            end
            FUNC_REMOVE:
            begin
                if (found)
                begin
                    status_next = ST_REMOVED;
                    ctrl.rem    = 1'b1;
                    count_next  = count_reg - 1'b1;
                end
            end
            FUNC_CLEAR:
            begin
                status_next = ST_CLEARED;
                ctrl.clr    = 1'b1;
                count_next  = '0;
            end
            default:
            begin
                status_next = ST_NOT_FOUND;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [VALUE_BITS-1:0] lv;
            logic                  lvld;
            logic                  llt;
            logic [VALUE_BITS-1:0] rv;
            logic                  rvld;

            if (gi == 0)
            begin : g_first
                // nothing sits left of slot 0: treat it as below every value
                assign lv   = value_reg;
                assign lvld = 1'b0;
                assign llt  = 1'b1;
            end
            else
            begin : g_mid_l
                assign lv   = cell_value[gi-1];
                assign lvld = cell_valid[gi-1];
                assign llt  = cell_lt[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign rv   = value_reg;
                assign rvld = 1'b0;
            end
            else
            begin : g_mid_r
                assign rv   = cell_value[gi+1];
                assign rvld = cell_valid[gi+1];
            end

            sus_cell #(
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .load        (accept),
                .cmp_value   (in_value),
                .ctrl        (ctrl),
                .new_value   (value_reg),
                .left_value  (lv),
                .left_valid  (lvld),
                .left_lt     (llt),
                .right_value (rv),
                .right_valid (rvld),
                .value_q     (cell_value[gi]),
                .valid_q     (cell_valid[gi]),
                .lt_q        (cell_lt[gi]),
                .eq_q        (cell_eq[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (do_upd)
            begin
                busy_reg <= 1'b0;
            end

            if (do_upd)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= s_tdata[FUNC_W-1:0];
            value_reg <= in_value;
        end
        if (do_upd)
        begin
            status_reg    <= status_next;
            out_count_reg <= out_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, status_reg};

endmodule

`default_nettype wire

@@ sim/sorted_unique_set_checker.sv @@
// ----------------------------------------------------------------------------
// sorted_unique_set_checker
// Watches both stream channels of the sorted unique set engine. Keeps its own
// copy of the set and works out the status and count of each input transfer.
// Each output transfer is compared, field by field, with the oldest reply
// still waiting.
// ----------------------------------------------------------------------------
module sorted_unique_set_checker #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,          // func[1:0], value[33:2], zero pad
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,          // status[2:0], entry_count[7:3]
    output int          mismatches,
    output int          replies_waiting,
    output int          replies_checked,
    output int          full_refusals,
    output int          duplicates
);
    timeunit 1ns;
    timeprecision 1ps;

    import sus_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } set_reply_t;

    // ascending contents of the set; only entries below set_size are used
    logic signed [IN_VAL_W-1:0] set_vals [CAPACITY];
    int                         set_size;
    set_reply_t                 pending_replies [$];
    int                         err_count;
    int                         checked_count;
    int                         full_count;
    int                         dup_count;

    function automatic set_reply_t apply_set_op(input logic [FUNC_W-1:0] op,
                                                input logic signed [IN_VAL_W-1:0] v);
        set_reply_t r;
        int         pos;
        int         i;
        bit         hit;
        pos = 0;
        while (pos < set_size && set_vals[pos] < v)
            pos++;
        hit = (pos < set_size) && (set_vals[pos] == v);
        case (op)
            FUNC_INSERT:
            begin
                // a duplicate is reported even on a full set
                if (hit)
                    r.status = ST_DUPLICATE;
                else if (set_size >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (i = set_size; i > pos; i--)
                        set_vals[i] = set_vals[i-1];
                    set_vals[pos] = v;
                    set_size++;
                    r.status = ST_INSERTED;
                end
            end
            FUNC_REMOVE:
            begin
                if (hit)
                begin
                    for (i = pos; i + 1 < set_size; i++)
                        set_vals[i] = set_vals[i+1];
                    set_size--;
                    r.status = ST_REMOVED;
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            FUNC_CLEAR:
            begin
                set_size = 0;
                r.status = ST_CLEARED;
            end
            default:
                r.status = ST_NOT_FOUND;   // unused code leaves the set alone
        endcase
        r.count = COUNT_W'(set_size);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        set_reply_t want;
        set_reply_t got;
        if (!rst_n)
        begin
            set_size        = 0;
            pending_replies.delete();
            err_count       = 0;
            checked_count   = 0;
            full_count      = 0;
            dup_count       = 0;
            mismatches      <= 0;
            replies_waiting <= 0;
            replies_checked <= 0;
            full_refusals   <= 0;
            duplicates      <= 0;
        end
        else
        begin
            // output side first: a reply never belongs to a same-edge input
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                checked_count++;
                if (pending_replies.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: unexpected reply, status %0d count %0d",
                                 $realtime, got.status, got.count);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (want.status == ST_FULL)
                        full_count++;
                    if (want.status == ST_DUPLICATE)
                        dup_count++;
                    if (got.status !== want.status || got.count !== want.count)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display("%0t: reply %0d: status exp %0d got %0d, count exp %0d got %0d",
                                     $realtime, checked_count, want.status, got.status,
                                     want.count, got.count);
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_replies.push_back(apply_set_op(s_tdata[1:0], s_tdata[33:2]));
            mismatches      <= err_count;
            replies_waiting <= pending_replies.size();
            replies_checked <= checked_count;
            full_refusals   <= full_count;
            duplicates      <= dup_count;
        end
    end

endmodule

@@ sim/sorted_unique_set_engine_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_unique_set_engine_tb
// Drives insert, remove and clear operations into the sorted unique set engine
// with random gaps and back-pressure; a separate checker predicts and compares
// every reply. Starts with a short directed run through the corner cases, then
// three random phases with different idling on each side.
// ----------------------------------------------------------------------------
module sorted_unique_set_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sus_pkg::*;

    localparam int                CAPACITY        = 16;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED     = 2'd3;
    localparam int                CYCLE_LIMIT     = 200000;
    localparam int                HOLD_OFF_CYCLES = 120;
    localparam int                POOL_SIZE       = 24;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;

    int mismatches;
    int replies_waiting;
    int replies_checked;
    int full_refusals;
    int duplicates;

    int  src_idle_pct;
    int  sink_idle_pct;
    bit  hold_off_req;
    int  ops_sent;
    int  cycle_count;

    // values reused often so that duplicates, hits on remove and a full set occur
    logic signed [IN_VAL_W-1:0] value_pool [POOL_SIZE];

    sorted_unique_set_engine u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sorted_unique_set_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .replies_waiting (replies_waiting),
        .replies_checked (replies_checked),
        .full_refusals   (full_refusals),
        .duplicates      (duplicates)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sorted_unique_set_engine test failed");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off when asked for
    initial
    begin
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                for (int n = 1; n < HOLD_OFF_CYCLES; n++)
                    @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic send_op(input logic [FUNC_W-1:0] op, input logic signed [IN_VAL_W-1:0] v);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, v, op};
        do
            @(posedge clk);
        while (!s_tready);
        ops_sent++;
    endtask

    task automatic send_random_op;
        logic [FUNC_W-1:0]          op;
        logic signed [IN_VAL_W-1:0] v;
        int                         r;
        r = $urandom_range(99);
        if (r < 56)
            op = FUNC_INSERT;
        else if (r < 96)
            op = FUNC_REMOVE;
        else if (r < 98)
            op = FUNC_CLEAR;
        else
            op = FUNC_UNUSED;
        if ($urandom_range(99) < 15)
            v = $urandom;
        else
            v = value_pool[$urandom_range(POOL_SIZE-1)];
        if ($urandom_range(49) == 0)
            value_pool[$urandom_range(POOL_SIZE-1)] = $urandom;
        send_op(op, v);
    endtask

    // stop offering and wait until every reply has come back
    task automatic drain_replies;
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (replies_waiting == 0);
        @(posedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        src_idle_pct  = 6;
        sink_idle_pct = 88;
        hold_off_req  = 1'b0;
        ops_sent      = 0;
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = 0;
        value_pool[3] = -1;
        value_pool[4] = 1;
        for (int i = 5; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send_op(FUNC_CLEAR, 0);                      // clear while empty
        send_op(FUNC_INSERT, 32'sh8000_0000);
        send_op(FUNC_INSERT, 32'sh7fff_ffff);
        send_op(FUNC_INSERT, 0);
        send_op(FUNC_INSERT, -1);
        send_op(FUNC_INSERT, 32'sh7fff_ffff);        // duplicate
        send_op(FUNC_REMOVE, 5);                     // not held
        send_op(FUNC_REMOVE, 32'sh8000_0000);
        send_op(FUNC_UNUSED, 32'shffff_ffff);
        for (int k = 0; k < 13; k++)
            send_op(FUNC_INSERT, (k - 6) * 1000003 + 5);
        send_op(FUNC_INSERT, 42);                    // set is full now
        send_op(FUNC_INSERT, 0);                     // duplicate beats full
        send_op(FUNC_CLEAR, 32'sh5a5a_a5a5);

        for (int k = 0; k < 600; k++)
            send_random_op();
        drain_replies();

        src_idle_pct  = 88;
        sink_idle_pct = 6;
        for (int k = 0; k < 600; k++)
            send_random_op();
        drain_replies();

        // full rate, opened by a long receiver hold-off so the input backs up
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_off_req  = 1'b1;
        for (int k = 0; k < 700; k++)
            send_random_op();
        drain_replies();
        repeat (8) @(posedge clk);

        $display("%0d operations in %0d cycles, %0d replies checked", ops_sent, cycle_count,
                 replies_checked);
        $display("%0d inserts refused on a full set, %0d duplicate inserts", full_refusals,
                 duplicates);
        if (mismatches == 0 && replies_waiting == 0)
            $display("sorted_unique_set_engine test passed");
        else
            $display("sorted_unique_set_engine test failed");
        $finish;
    end

endmodule
